FILE: src/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg: shared constants and functions of the cube corner case classifier
// Holds the cube rotations, the reference corner patterns and the
// classification function used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

    localparam int NumCorners  = 8;
    localparam int HalfCorners = 4;
    localparam int NumPatterns = 13;
    localparam int NumFaces    = 6;
    localparam int NumTurns    = 4;

    localparam int MaskW  = NumCorners;
    localparam int ClassW = 4;
    localparam int CountW = $clog2(NumCorners + 1);

    typedef logic [MaskW-1:0]  mask_t;
    typedef logic [ClassW-1:0] class_t;
    typedef logic [CountW-1:0] count_t;

    // class codes with a fixed meaning
    localparam class_t CLASS_EMPTY  = class_t'(0);
    localparam class_t CLASS_SINGLE = class_t'(1);

    // reference patterns, searched in this order
    localparam count_t PAT_COUNT [NumPatterns] = '{
        count_t'(2), count_t'(2), count_t'(2),
        count_t'(3), count_t'(3), count_t'(3),
        count_t'(4), count_t'(4), count_t'(4), count_t'(4),
        count_t'(4), count_t'(4), count_t'(4)
    };
    localparam mask_t PAT_BITS [NumPatterns] = '{
        8'h03, 8'h21, 8'h41,
        8'h07, 8'h43, 8'h25,
        8'h0F, 8'h87, 8'hA5, 8'h27,
        8'h4D, 8'h8E, 8'hC3
    };
    localparam class_t PAT_CLASS [NumPatterns] = '{
        class_t'(2),  class_t'(3),  class_t'(4),
        class_t'(5),  class_t'(6),  class_t'(7),
        class_t'(8),  class_t'(9),  class_t'(10), class_t'(11),
        class_t'(12), class_t'(13), class_t'(14)
    };

    // quarter turn about z: corner k moves to 1,2,3,0,5,6,7,4
    function automatic mask_t rot_z(input mask_t m);
        mask_t r;
        r[1] = m[0];
        r[2] = m[1];
        r[3] = m[2];
        r[0] = m[3];
        r[5] = m[4];
        r[6] = m[5];
        r[7] = m[6];
        r[4] = m[7];
        return r;
    endfunction

    // quarter turn about y: corner k moves to 4,0,3,7,5,1,2,6
    function automatic mask_t rot_y(input mask_t m);
        mask_t r;
        r[4] = m[0];
        r[0] = m[1];
        r[3] = m[2];
        r[7] = m[3];
        r[5] = m[4];
        r[1] = m[5];
        r[2] = m[6];
        r[6] = m[7];
        return r;
    endfunction

    function automatic count_t popcount(input mask_t m);
        count_t n;
        n = '0;
        for (int k = 0; k < NumCorners; k++) begin
            n = n + count_t'(m[k]);
        end
        return n;
    endfunction

    // case number of a corner mask; rotations are pure wiring, the
    // pattern compares run in parallel behind one priority select
    function automatic class_t classify(input mask_t mask);
        count_t n;
        count_t eff;
        mask_t  m;
        mask_t  face;
        mask_t  cur;
        logic   found;
        class_t cls;
        n     = popcount(mask);
        m     = mask;
        eff   = n;
        found = 1'b0;
        cls   = CLASS_EMPTY;
        if (n > count_t'(HalfCorners)) begin
            eff = count_t'(NumCorners) - n;
            m   = ~mask;
        end
        if (eff == '0) begin
            cls = CLASS_EMPTY;
        end else if (eff == count_t'(1)) begin
            cls = CLASS_SINGLE;
        end else begin
            face = m;
            for (int i = 0; i < NumFaces; i++) begin
                cur = face;
                for (int j = 0; j < NumTurns; j++) begin
                    for (int p = 0; p < NumPatterns; p++) begin
                        if (!found && PAT_COUNT[p] == eff &&
                            (cur & PAT_BITS[p]) == PAT_BITS[p]) begin
                            found = 1'b1;
                            cls   = PAT_CLASS[p];
                        end
                    end
                    cur = rot_z(cur);
                end
                // move on to the next face orientation
                if (i == 4) begin
                    face = rot_y(rot_y(face));
                end else if (i == 3) begin
                    face = rot_y(rot_z(face));
                end else begin
                    face = rot_y(face);
                end
            end
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: src/cube_corner_case_classifier.sv
// ----------------------------------------------------------------------------
// cube_corner_case_classifier: marching-cubes case number of a corner mask
// Maps an 8-bit inside/outside corner mask to one of 15 case numbers.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one item per voxel cube, s_tdata[7:0] is the corner mask.
//   m_ channel: one item per input item, m_tdata[3:0] is the case number
//   (0 to 14), m_tdata[7:4] is zero.
//   Path: an accepted item passes the input register, then the result
//   register, before it is shown on m_tvalid.
//   Throughput: one item per cycle while the receiver does not stall; the
//   classification is a single pass of compare logic between the two registers.
//   Reset (aresetn low, synchronous) empties both registers; m_tvalid drops
//   and s_tready rises in the cycle after.
//   When the receiver stalls, the result register holds its item, the input
//   register still takes one more item, and s_tready then falls until the
//   result register is freed.
//   Results leave in the order the items came in.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_corner_case_classifier (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] corner_mask
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [3:0] case_class, [7:4] zero
);

    import ccc_pkg::*;

    logic   in_valid_reg;
    logic   in_valid_next;
    mask_t  in_mask_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    class_t out_class_reg;
    class_t out_class_comb;
    logic   out_load;
    logic   in_load;

    // handshake: each stage takes a new item when empty or when it moves on
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_reg);
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    // classification between the two registers
    assign out_class_comb = classify(in_mask_reg);

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_mask_reg <= s_tdata;
        end
        if (out_load && in_valid_reg) begin
            out_class_reg <= out_class_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - ClassW){1'b0}}, out_class_reg};

endmodule

`default_nettype wire

FILE: src/ccc_checker.sv
// ----------------------------------------------------------------------------
// ccc_checker: port-level checks for the cube corner case classifier
// Watches the top level's ports and flags illegal results or handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // reset empties the result side
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // case numbers stop at 14
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:0] != 4'hF)
        else $error("case number out of range");

    // padding bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'h0)
        else $error("nonzero padding in result");

    // an item accepted while no result is offered reaches m_tvalid through both registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
        else $error("result missing after accepted item");

endmodule

bind cube_corner_case_classifier ccc_checker u_ccc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/cube_corner_case_classifier_tb.sv
// ----------------------------------------------------------------------------
// cube_corner_case_classifier_tb: self-checking bench for the case classifier
// Drives corner masks into the s_ stream and checks every m_ item, in order, with a
// typed-in case or a local predictor of the marching-cubes case number. A short table
// of hand-picked masks comes first, then random masks with random idling on
// both sides, one long receiver stall and one full drain of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_corner_case_classifier_tb;

    import ccc_pkg::*;

    localparam int RandomItems   = 800;
    localparam int StallCycles   = 120;
    localparam int WatchdogLimit = 3000;
    localparam int TailCycles    = 8;
    localparam int NumShapes     = 13;
    localparam int NumProbes     = 25;

    // case numbers past the empty and single-corner cases
    localparam class_t CASE_EDGE_PAIR      = class_t'(2);
    localparam class_t CASE_FACE_PAIR      = class_t'(3);
    localparam class_t CASE_BODY_PAIR      = class_t'(4);
    localparam class_t CASE_TRI_CORNER     = class_t'(5);
    localparam class_t CASE_TRI_EDGE_FAR   = class_t'(6);
    localparam class_t CASE_TRI_SPREAD     = class_t'(7);
    localparam class_t CASE_QUAD_FACE      = class_t'(8);
    localparam class_t CASE_QUAD_L_FAR     = class_t'(9);
    localparam class_t CASE_QUAD_TETRA     = class_t'(10);
    localparam class_t CASE_QUAD_STAR      = class_t'(11);
    localparam class_t CASE_QUAD_SKEW_LEFT = class_t'(12);
    localparam class_t CASE_QUAD_SKEW_RGHT = class_t'(13);
    localparam class_t CASE_QUAD_TWIN_EDGE = class_t'(14);

    // corner shapes searched in this order, first hit wins
    localparam int SHAPE_SIZE [NumShapes] = '{2, 2, 2, 3, 3, 3, 4, 4, 4, 4, 4, 4, 4};
    localparam logic [7:0] SHAPE_BITS [NumShapes] = '{
        8'h03, 8'h21, 8'h41, 8'h07, 8'h43, 8'h25,
        8'h0F, 8'h87, 8'hA5, 8'h27, 8'h4D, 8'h8E, 8'hC3
    };
    localparam class_t SHAPE_CASE [NumShapes] = '{
        CASE_EDGE_PAIR, CASE_FACE_PAIR, CASE_BODY_PAIR,
        CASE_TRI_CORNER, CASE_TRI_EDGE_FAR, CASE_TRI_SPREAD,
        CASE_QUAD_FACE, CASE_QUAD_L_FAR, CASE_QUAD_TETRA, CASE_QUAD_STAR,
        CASE_QUAD_SKEW_LEFT, CASE_QUAD_SKEW_RGHT, CASE_QUAD_TWIN_EDGE
    };

    // where each corner lands under a quarter turn about z and about y
    localparam int Z_TO [NumCorners] = '{1, 2, 3, 0, 5, 6, 7, 4};
    localparam int Y_TO [NumCorners] = '{4, 0, 3, 7, 5, 1, 2, 6};

    typedef struct packed {
        logic [7:0] mask;
        logic       known;
        class_t     want;
    } probe_t;

    // hand-picked masks; the case is typed in where it is plain to see
    localparam probe_t PROBES [NumProbes] = '{
        '{8'h00, 1'b1, CLASS_EMPTY},
        '{8'hFF, 1'b1, CLASS_EMPTY},
        '{8'h01, 1'b1, CLASS_SINGLE},
        '{8'h80, 1'b1, CLASS_SINGLE},
        '{8'hFE, 1'b1, CLASS_SINGLE},
        '{8'h7F, 1'b1, CLASS_SINGLE},
        '{8'h03, 1'b1, CASE_EDGE_PAIR},
        '{8'h21, 1'b1, CASE_FACE_PAIR},
        '{8'h41, 1'b1, CASE_BODY_PAIR},
        '{8'h07, 1'b1, CASE_TRI_CORNER},
        '{8'h43, 1'b1, CASE_TRI_EDGE_FAR},
        '{8'h25, 1'b1, CASE_TRI_SPREAD},
        '{8'h0F, 1'b1, CASE_QUAD_FACE},
        '{8'h87, 1'b1, CASE_QUAD_L_FAR},
        '{8'hA5, 1'b1, CASE_QUAD_TETRA},
        '{8'h27, 1'b1, CASE_QUAD_STAR},
        '{8'h4D, 1'b1, CASE_QUAD_SKEW_LEFT},
        '{8'h8E, 1'b1, CASE_QUAD_SKEW_RGHT},
        '{8'hC3, 1'b1, CASE_QUAD_TWIN_EDGE},
        '{8'hFC, 1'b1, CASE_EDGE_PAIR},
        '{8'hBE, 1'b1, CASE_BODY_PAIR},
        '{8'hF0, 1'b0, CLASS_EMPTY},
        '{8'h5A, 1'b0, CLASS_EMPTY},
        '{8'h81, 1'b0, CLASS_EMPTY},
        '{8'h1F, 1'b0, CLASS_EMPTY}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] corner_mask
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [3:0] case_class, [7:4] zero

    class_t case_queue [$];
    class_t offered_case;
    bit     calm       = 1'b0;
    bit     stall_req  = 1'b0;
    int     stall_left = 0;
    int     idle_cycles = 0;
    int     mismatches  = 0;
    int     results_checked = 0;
    int     random_sent = 0;
    bit     cases_seen [16];

    cube_corner_case_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // quarter turn of the whole cube, about y or about z
    function automatic mask_t turn_cube(input mask_t m, input bit about_y);
        mask_t r;
        r = '0;
        for (int k = 0; k < NumCorners; k++) begin
            if (m[k]) begin
                r[about_y ? Y_TO[k] : Z_TO[k]] = 1'b1;
            end
        end
        return r;
    endfunction

    // expected case number of one corner mask
    function automatic class_t predict_case(input mask_t mask);
        int    ones;
        int    size;
        mask_t m;
        ones = 0;
        for (int k = 0; k < NumCorners; k++) begin
            ones += int'(mask[k]);
        end
        size = (ones > HalfCorners) ? NumCorners - ones : ones;
        m    = (ones > HalfCorners) ? ~mask : mask;
        if (size == 0) begin
            return CLASS_EMPTY;
        end
        if (size == 1) begin
            return CLASS_SINGLE;
        end
        // 24 orientations: four z turns on each of six faces
        for (int face = 0; face < 6; face++) begin
            for (int turn = 0; turn < 4; turn++) begin
                for (int s = 0; s < NumShapes; s++) begin
                    if (SHAPE_SIZE[s] == size && (m & SHAPE_BITS[s]) == SHAPE_BITS[s]) begin
                        return SHAPE_CASE[s];
                    end
                end
                m = turn_cube(m, 1'b0);
            end
            if (face == 4) begin
                m = turn_cube(turn_cube(m, 1'b1), 1'b1);
            end else if (face == 3) begin
                m = turn_cube(turn_cube(m, 1'b0), 1'b1);
            end else begin
                m = turn_cube(m, 1'b1);
            end
        end
        return CLASS_EMPTY;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    // offer one item, with random idle cycles ahead of it
    task automatic offer_mask(input mask_t mask, input bit known, input class_t want);
        while (!calm && $urandom_range(0, 99) < 9) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid     <= 1'b1;
        s_tdata      <= mask;
        offered_case  = known ? want : predict_case(mask);
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (case_queue.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // receiver: random back-pressure, plus one long stall on request
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_req) begin
            stall_req   = 1'b0;
            m_tready   <= 1'b0;
            stall_left <= StallCycles - 1;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    // record accepted items and check results in order
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            cases_seen[m_tdata[3:0]] = 1'b1;
            if (case_queue.size() == 0) begin
                report_mismatch("result with no item waiting", int'(m_tdata), 0);
            end else begin
                class_t want;
                want = case_queue.pop_front();
                if (m_tdata[3:0] != want) begin
                    report_mismatch("case_class", int'(m_tdata[3:0]), int'(want));
                end
                if (m_tdata[7:4] != 4'h0) begin
                    report_mismatch("m_tdata padding", int'(m_tdata[7:4]), 0);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            case_queue.push_back(offered_case);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("timeout: no item moved for %0d cycles", WatchdogLimit);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        mask_t m;
        int    seen;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed masks
        for (int p = 0; p < NumProbes; p++) begin
            offer_mask(PROBES[p].mask, PROBES[p].known, PROBES[p].want);
        end

        // random masks: uniform, or a shape turned at random and maybe inverted
        for (int i = 0; i < RandomItems; i++) begin
            calm = (i >= 200 && i < 320);
            if (i == 400) begin
                stall_req = 1'b1;
            end
            if (i == 600) begin
                drain_results();
            end
            if ($urandom_range(0, 99) < 30) begin
                m = SHAPE_BITS[$urandom_range(0, NumShapes - 1)];
                repeat ($urandom_range(0, 7)) begin
                    m = turn_cube(m, 1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 1) == 1) begin
                    m = ~m;
                end
            end else begin
                m = mask_t'($urandom_range(0, 255));
            end
            offer_mask(m, 1'b0, CLASS_EMPTY);
            random_sent++;
        end
        calm = 1'b0;

        // wind down
        drain_results();
        repeat (TailCycles) @(posedge aclk);
        if (case_queue.size() != 0) begin
            report_mismatch("results missing at end", 0, case_queue.size());
        end

        seen = 0;
        foreach (cases_seen[c]) begin
            seen += int'(cases_seen[c]);
        end
        $display("checked %0d results from %0d table masks and %0d random masks",
                 results_checked, NumProbes, random_sent);
        $display("distinct case numbers observed: %0d of 15, mismatches: %0d",
                 seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
